// ----- sv/eig2_pkg.sv -----
// shared types and constants for the 2x2 eigenvalue core
package eig2_pkg;

    // radicand bits consumed by one square-root cell, which resolves one root bit
    localparam int BITS_PER_CELL = 2;

    // the discriminant uses four times the off-diagonal product
    localparam int OFFDIAG_SHIFT = 2;

    // control that travels alongside every pipeline slot
    typedef struct packed {
        logic valid;
        logic clamped;
    } t_ctl;

endpackage

// ----- sv/eig2_disc.sv -----
// trace and clamped discriminant, three register stages
module eig2_disc #(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ENTRY_WIDTH-1:0] i_a00,
    input  logic signed [ENTRY_WIDTH-1:0] i_a01,
    input  logic signed [ENTRY_WIDTH-1:0] i_a10,
    input  logic signed [ENTRY_WIDTH-1:0] i_a11,
    input  logic                         i_ready,
    output eig2_pkg::t_ctl               o_ctl,
    output logic signed [ENTRY_WIDTH:0]  o_b,
    output logic [2*ENTRY_WIDTH+1:0]     o_rad
);
    import eig2_pkg::*;

    localparam int W      = ENTRY_WIDTH;
    localparam int DISC_W = 2 * W + 3;

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    logic signed [W:0]       r_b1, r_b2, r_b3;
    logic signed [W:0]       r_dif;
    logic signed [2*W-1:0]   r_p1, r_p2;
    logic signed [2*W+1:0]   r_sq;
    logic [2*W+1:0]          r_rad;
    logic                    r_clamped;

    logic signed [2*W-1:0]   w_p;
    logic signed [2*W+1:0]   w_sq;
    logic signed [DISC_W-1:0] w_disc;

    // a stage moves when it is empty or its successor moves
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    assign w_p  = i_a01 * i_a10;
    assign w_sq = r_dif * r_dif;
    // (a00 - a11)^2 + 4*a01*a10 equals b*b - 4*det exactly
    assign w_disc = {r_sq[2*W+1], r_sq} + {r_p2[2*W-1], r_p2, {OFFDIAG_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_b1  <= {i_a00[W-1], i_a00} + {i_a11[W-1], i_a11};
            r_dif <= {i_a00[W-1], i_a00} - {i_a11[W-1], i_a11};
            r_p1  <= w_p;
        end
        if (w_en2) begin
            r_b2 <= r_b1;
            r_sq <= w_sq;
            r_p2 <= r_p1;
        end
        if (w_en3) begin
            r_b3      <= r_b2;
            r_clamped <= w_disc[DISC_W-1];
            r_rad     <= w_disc[DISC_W-1] ? '0 : w_disc[2*W+1:0];
        end
    end

    assign o_ctl.valid   = r_v3;
    assign o_ctl.clamped = r_clamped;
    assign o_b           = r_b3;
    assign o_rad         = r_rad;

endmodule

// ----- sv/eig2_sqrt_cell.sv -----
// one digit cell of the pipelined square-root chain
module eig2_sqrt_cell #(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eig2_pkg::t_ctl               i_ctl,
    output logic                         o_ready,
    input  logic signed [ENTRY_WIDTH:0]  i_b,
    input  logic [2*ENTRY_WIDTH+1:0]     i_rad,
    input  logic [ENTRY_WIDTH+2:0]       i_rem,
    input  logic [ENTRY_WIDTH:0]         i_root,
    input  logic                         i_ready,
    output eig2_pkg::t_ctl               o_ctl,
    output logic signed [ENTRY_WIDTH:0]  o_b,
    output logic [2*ENTRY_WIDTH+1:0]     o_rad,
    output logic [ENTRY_WIDTH+2:0]       o_rem,
    output logic [ENTRY_WIDTH:0]         o_root
);
    import eig2_pkg::*;

    localparam int ROOT_W = ENTRY_WIDTH + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic                    r_valid;
    logic                    r_clamped;
    logic signed [ROOT_W-1:0] r_b;
    logic [RAD_W-1:0]        r_rad;
    logic [REM_W-1:0]        r_rem;
    logic [ROOT_W-1:0]       r_root;

    logic [REM_W-1:0]        w_rem_sh;
    logic [REM_W-1:0]        w_trial;
    logic                    w_ge;
    logic [REM_W-1:0]        n_rem;
    logic [ROOT_W-1:0]       n_root;
    logic [RAD_W-1:0]        n_rad;

    assign o_ready = !r_valid || i_ready;

    // bring down the next two radicand bits and try root digit 1
    assign w_rem_sh = {i_rem[ROOT_W-1:0], i_rad[RAD_W-1 -: BITS_PER_CELL]};
    assign w_trial  = {i_root, {(BITS_PER_CELL-1){1'b0}}, 1'b1};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign n_rem    = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
    assign n_root   = {i_root[ROOT_W-2:0], w_ge};
    assign n_rad    = {i_rad[RAD_W-BITS_PER_CELL-1:0], {BITS_PER_CELL{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_clamped <= i_ctl.clamped;
            r_b       <= i_b;
            r_rad     <= n_rad;
            r_rem     <= n_rem;
            r_root    <= n_root;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.clamped = r_clamped;
    assign o_b           = r_b;
    assign o_rad         = r_rad;
    assign o_rem         = r_rem;
    assign o_root        = r_root;

endmodule

// ----- sv/eig2_out.sv -----
// final add, floor halving and output register
module eig2_out #(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  eig2_pkg::t_ctl                i_ctl,
    output logic                          o_ready,
    input  logic signed [ENTRY_WIDTH:0]   i_b,
    input  logic [ENTRY_WIDTH:0]          i_root,
    input  logic                          i_m_ready,
    output logic                          o_valid,
    output logic signed [ENTRY_WIDTH+1:0] o_low,
    output logic signed [ENTRY_WIDTH+1:0] o_high,
    output logic                          o_clamped
);
    import eig2_pkg::*;

    localparam int W     = ENTRY_WIDTH;
    localparam int SUM_W = W + 3;

    logic                    r_valid;
    logic signed [W+1:0]     r_low;
    logic signed [W+1:0]     r_high;
    logic                    r_clamped;

    logic signed [SUM_W-1:0] w_b_ext;
    logic signed [SUM_W-1:0] w_s_ext;
    logic signed [SUM_W-1:0] w_low;
    logic signed [SUM_W-1:0] w_high;

    assign o_ready = !r_valid || i_m_ready;

    assign w_b_ext = {{2{i_b[W]}}, i_b};
    assign w_s_ext = {2'b00, i_root};
    assign w_low   = w_b_ext - w_s_ext;
    assign w_high  = w_b_ext + w_s_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    // dropping the lsb of a two's complement sum rounds toward minus infinity
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_low     <= w_low[SUM_W-1:1];
            r_high    <= w_high[SUM_W-1:1];
            r_clamped <= i_ctl.clamped;
        end
    end

    assign o_valid   = r_valid;
    assign o_low     = r_low;
    assign o_high    = r_high;
    assign o_clamped = r_clamped;

endmodule

// ----- sv/eigenvalues_2x2_core.sv -----
// top level of the streaming 2x2 real matrix eigenvalue core
//
// slave channel: one transfer carries a full matrix, entries a00, a01, a10, a11
// in signed fixed point, packed from the low bits of i_s_tdata
// master channel: one transfer per matrix, the two eigenvalue halves
// (b - s)/2 and (b + s)/2 in o_m_tdata, smaller first, and o_m_tuser set
// when the discriminant came out negative and was forced to zero
// pipeline: 3 discriminant stages, ENTRY_WIDTH + 1 root cells, 1 output stage
// throughput: one matrix per cycle while the master side does not stall,
// set by the root chain that resolves one root bit per cell while every
// cell holds a different matrix
// stall: each stage advances when it is empty or its successor advances, so
// bubbles collapse and o_s_tready stays high until every slot is full;
// the output register holds its transfer stable until i_m_tready
// reset: synchronous active low clears all valid bits, no results pending;
// the data registers are not reset
module eigenvalues_2x2_core #(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // fields from bit 0 up: a00, a01, a10, a11, zero pad to whole bytes
    input  logic [((4*ENTRY_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // fields from bit 0 up: eig_low, eig_high, zero pad to whole bytes
    output logic [((2*(ENTRY_WIDTH+2)+7)/8)*8-1:0] o_m_tdata,
    // fields from bit 0 up: clamped
    output logic [0:0] o_m_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready
);
    import eig2_pkg::*;

    localparam int W          = ENTRY_WIDTH;
    localparam int ROOT_W     = W + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int N_CELLS    = ROOT_W;
    localparam int OUT_W      = W + 2;
    localparam int OUT_DATA_W = ((2*OUT_W+7)/8)*8;

    // matrix entries unpacked from the input transfer
    logic signed [W-1:0] w_a00, w_a01, w_a10, w_a11;

    assign w_a00 = i_s_tdata[0*W +: W];
    assign w_a01 = i_s_tdata[1*W +: W];
    assign w_a10 = i_s_tdata[2*W +: W];
    assign w_a11 = i_s_tdata[3*W +: W];

    // slot k of the chain feeds root cell k; slot N_CELLS feeds the output stage
    t_ctl                w_ctl  [0:N_CELLS];
    logic signed [W:0]   w_b    [0:N_CELLS];
    logic [RAD_W-1:0]    w_rad  [0:N_CELLS];
    logic [REM_W-1:0]    w_rem  [0:N_CELLS];
    logic [ROOT_W-1:0]   w_root [0:N_CELLS];
    logic                w_rdy  [0:N_CELLS];

    logic signed [OUT_W-1:0] w_low;
    logic signed [OUT_W-1:0] w_high;
    logic                    w_clamped;

    // trace and discriminant front end
    eig2_disc #(
        .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_a00   (w_a00),
        .i_a01   (w_a01),
        .i_a10   (w_a10),
        .i_a11   (w_a11),
        .i_ready (w_rdy[0]),
        .o_ctl   (w_ctl[0]),
        .o_b     (w_b[0]),
        .o_rad   (w_rad[0])
    );

    // the root and remainder start empty for each matrix
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // square-root chain, most significant root bit in the first cell
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        eig2_sqrt_cell #(
            .ENTRY_WIDTH(ENTRY_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .o_ready (w_rdy[k]),
            .i_b     (w_b[k]),
            .i_rad   (w_rad[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_ready (w_rdy[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_b     (w_b[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    // output stage doubles as the master-side register
    eig2_out #(
        .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl[N_CELLS]),
        .o_ready   (w_rdy[N_CELLS]),
        .i_b       (w_b[N_CELLS]),
        .i_root    (w_root[N_CELLS]),
        .i_m_ready (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_low     (w_low),
        .o_high    (w_high),
        .o_clamped (w_clamped)
    );

    assign o_m_tdata = OUT_DATA_W'({w_high, w_low});
    assign o_m_tuser = w_clamped;

    // the whole radicand has been consumed at the end of the chain
    a_rad_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[N_CELLS].valid |-> (w_rad[N_CELLS] == '0))
        else $error("radicand bits left over after last root cell");

    // a floor root leaves a remainder of at most twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[N_CELLS].valid |-> (w_rem[N_CELLS] <= {1'b0, w_root[N_CELLS], 1'b0}))
        else $error("square root remainder out of range");

    // the smaller eigenvalue never exceeds the larger one
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_low <= w_high))
        else $error("eigenvalue order violated");

    // a clamped discriminant gives a zero root, so both halves match
    a_clamp_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_clamped) |-> (w_low == w_high))
        else $error("clamped result with differing eigenvalues");

endmodule
